@@ design/wang_landau_sampler_defines.svh @@
// assertion macros for the wang-landau sampler
// no dependencies; included by wang_landau_sampler, which checks itself
`ifndef WANG_LANDAU_SAMPLER_DEFINES_SVH
`define WANG_LANDAU_SAMPLER_DEFINES_SVH

// consequence holds in the same cycle
`define WLS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence holds in the next cycle
`define WLS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/wls_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the wang-landau sampler
// no dependencies
package wls_pkg;

   localparam int BINS   = 64;
   localparam int ADDR_W = $clog2(BINS);
   localparam int CNT_W  = $clog2(BINS + 1);

   // ln 2 in q0.32 and the exp cutoff of 12.0 in q32.32
   localparam logic [35:0] LN2_Q32   = 36'd2977044472;
   localparam logic [63:0] EXP_LIMIT = 64'd12 << 32;
   localparam logic [3:0]  EXP_TERMS = 4'd12;
   localparam logic [5:0]  MAX_STAGE = 6'd32;

   // op codes
   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_PROPOSE = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   // register indexes
   localparam logic [1:0] REG_BINS  = 2'd0;
   localparam logic [1:0] REG_FINAL = 2'd1;
   localparam logic [1:0] REG_FLAT  = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [5:0]  bin_index;
      logic        in_range;
      logic [15:0] random_draw;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [5:0]  current_bin;
      logic [5:0]  stage;
      logic        flat_now;
      logic        finished;
      logic [63:0] log_density_value;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD_CUR, S_CHECK, S_REDUCE, S_MUL, S_DIV, S_PROB,
      S_UPD_RD, S_UPD_WR, S_SCAN, S_FLAT_MUL, S_FLAT_CMP, S_QUERY, S_EMIT
   } state_type;

endpackage

@@ design/wang_landau_sampler.sv @@
`timescale 1ns / 1ps
// wang-landau acceptance and histogram engine, one module
// uses wls_pkg and the assertion macros of wang_landau_sampler_defines.svh
// a query reads one entry; start clears both memories over all 64 entries; a proposal reads,
// evaluates exp(-x) when needed, updates, scans the used bins, and clears the histogram when flat
// one word at a time; busy covers the whole item, the result strobe is one cycle
// the exp series (one shared multiplier, 4-bit-a-cycle divider) and the min scan set the rate
// synchronous reset starts a clearing pass of both memories with busy high
`include "wang_landau_sampler_defines.svh"

module wang_landau_sampler (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  wls_pkg::req_type  req_word,
   output logic              rsp_valid,
   output wls_pkg::rsp_type  rsp_word,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import wls_pkg::*;

   state_type state_ff, state_in;

   logic [6:0]  bins_ff;
   logic [5:0]  final_ff;
   logic [8:0]  flat_q8_ff;

   req_type     req_ff;
   logic [ADDR_W-1:0] walker_ff;
   logic [5:0]  stage_ff;
   logic [31:0] total_ff;
   logic [CNT_W-1:0] clr_idx_ff;
   logic        clr_g_ff, clr_boot_ff;
   logic [63:0] gc_ff, val_ff;
   logic        acc_ff, flat_ff;
   logic [35:0] rem_ff;
   logic [4:0]  n_ff;
   logic [32:0] t_ff;
   logic [33:0] e_ff;
   logic [3:0]  k_ff;
   logic [31:0] dnum_ff;
   logic [3:0]  drem_ff;
   logic [2:0]  dcnt_ff;
   logic [CNT_W-1:0] scan_idx_ff;
   logic        scan_vld_ff;
   logic [31:0] min_ff;
   logic [38:0] lhs_ff;
   logic [40:0] rhs_ff;

   // memories
   logic [63:0] g_mem [BINS];
   logic [31:0] h_mem [BINS];
   logic [63:0] g_rd_ff;
   logic [31:0] h_rd_ff;
   logic        g_we, h_we;
   logic [ADDR_W-1:0] g_wa, h_wa, g_ra, h_ra;
   logic [63:0] g_wd;
   logic [31:0] h_wd;

   logic [CNT_W-1:0] used_w;
   logic [5:0]  last_w;
   logic        finished_w, cfg_wr, acc0_w, scan_issue_w;
   logic [ADDR_W-1:0] cur_w, start_bin_w;
   logic [63:0] x_w, g_upd_w;
   logic [64:0] g_sum_w;
   logic [31:0] h_upd_w, total_upd_w;
   logic [4:0]  dr_w;
   logic [3:0]  dq_w;
   logic [3:0]  dr_out_w;
   logic [33:0] p_w;
   logic [64:0] prod_w;

   // effective configuration
   always_comb begin
      if (bins_ff < 7'd2) begin
         used_w = CNT_W'(2);
      end else if ({{(32-7){1'b0}}, bins_ff} > 32'(BINS)) begin
         used_w = CNT_W'(BINS);
      end else begin
         used_w = CNT_W'(bins_ff);
      end
      last_w = (final_ff > MAX_STAGE) ? MAX_STAGE : final_ff;
   end
   assign finished_w = stage_ff >= last_w;

   // start bin clamped into the used bins
   assign start_bin_w = ({1'b0, req_word.bin_index} < 7'(used_w)) ? req_word.bin_index
                                                                   : ADDR_W'(used_w - 1'b1);

   // datapath helpers
   assign acc0_w   = req_ff.in_range && ({1'b0, req_ff.bin_index} < 7'(used_w));
   assign cur_w    = acc_ff ? req_ff.bin_index : walker_ff;
   assign x_w      = g_rd_ff - gc_ff;
   assign g_sum_w  = {1'b0, g_rd_ff} + (65'd1 << (6'd32 - stage_ff));
   assign g_upd_w  = g_sum_w[64] ? {64{1'b1}} : g_sum_w[63:0];
   assign h_upd_w  = (h_rd_ff == 32'hFFFF_FFFF) ? h_rd_ff : h_rd_ff + 32'd1;
   assign total_upd_w = (total_ff == 32'hFFFF_FFFF) ? total_ff : total_ff + 32'd1;
   assign scan_issue_w = scan_idx_ff < used_w;
   assign prod_w   = t_ff * {1'b0, rem_ff[31:0]};
   assign p_w      = e_ff >> n_ff;
   assign cfg_wr   = psel && penable && pwrite && pready;

   // four quotient bits of (t * rem) / k a cycle
   always_comb begin
      dr_w = {1'b0, drem_ff};
      dq_w = 4'd0;
      for (int i = 0; i < 4; i++) begin
         dr_w = {dr_w[3:0], dnum_ff[31 - i]};
         if (dr_w >= {1'b0, k_ff}) begin
            dr_w = dr_w - {1'b0, k_ff};
            dq_w[3 - i] = 1'b1;
         end
      end
      dr_out_w = dr_w[3:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_idx_ff == CNT_W'(BINS - 1)) state_in = clr_boot_ff ? S_IDLE : S_EMIT;
         end
         S_IDLE: begin
            if (start) begin
               case (req_word.op)
                  OP_START:   state_in = S_CLEAR;
                  OP_PROPOSE: state_in = finished_w ? S_EMIT : S_RD_CUR;
                  OP_READ:    state_in = S_QUERY;
                  default:    state_in = S_EMIT;
               endcase
            end
         end
         S_RD_CUR: state_in = S_CHECK;
         S_CHECK: begin
            if (!acc0_w || gc_ff >= g_rd_ff || x_w >= EXP_LIMIT) state_in = S_UPD_RD;
            else state_in = S_REDUCE;
         end
         S_REDUCE: begin
            if (rem_ff < LN2_Q32) state_in = S_MUL;
         end
         S_MUL: state_in = S_DIV;
         S_DIV: begin
            if (dcnt_ff == 3'd7) state_in = (k_ff == EXP_TERMS) ? S_PROB : S_MUL;
         end
         S_PROB:     state_in = S_UPD_RD;
         S_UPD_RD:   state_in = S_UPD_WR;
         S_UPD_WR:   state_in = S_SCAN;
         S_SCAN: begin
            if (!scan_issue_w && !scan_vld_ff) state_in = S_FLAT_MUL;
         end
         S_FLAT_MUL: state_in = S_FLAT_CMP;
         S_FLAT_CMP: begin
            if (min_ff != 32'd0 && {lhs_ff, 8'd0} >= {6'd0, rhs_ff}) state_in = S_CLEAR;
            else state_in = S_EMIT;
         end
         S_QUERY:    state_in = S_EMIT;
         S_EMIT:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs and memory control
   always_comb begin
      busy      = state_ff != S_IDLE;
      rsp_valid = state_ff == S_EMIT;
      g_we = 1'b0;
      h_we = 1'b0;
      g_wa = cur_w;
      h_wa = cur_w;
      g_wd = g_upd_w;
      h_wd = h_upd_w;
      g_ra = walker_ff;
      h_ra = cur_w;
      case (state_ff)
         S_CLEAR: begin
            g_we = clr_g_ff;
            h_we = 1'b1;
            g_wa = clr_idx_ff[ADDR_W-1:0];
            h_wa = clr_idx_ff[ADDR_W-1:0];
            g_wd = 64'd0;
            h_wd = 32'd0;
         end
         S_IDLE:   g_ra = (req_word.op == OP_READ) ? req_word.bin_index : walker_ff;
         S_RD_CUR: g_ra = req_ff.bin_index;
         S_UPD_RD: begin
            g_ra = cur_w;
            h_ra = cur_w;
         end
         S_UPD_WR: begin
            g_we = 1'b1;
            h_we = 1'b1;
         end
         S_SCAN:   h_ra = scan_idx_ff[ADDR_W-1:0];
         default: ;
      endcase
   end

   assign rsp_word.accepted          = acc_ff;
   assign rsp_word.current_bin       = walker_ff;
   assign rsp_word.stage             = stage_ff;
   assign rsp_word.flat_now          = flat_ff;
   assign rsp_word.finished          = finished_w;
   assign rsp_word.log_density_value = val_ff;

   // memory ports
   always_ff @(posedge clock) begin
      if (g_we) g_mem[g_wa] <= g_wd;
      if (h_we) h_mem[h_wa] <= h_wd;
      g_rd_ff <= g_mem[g_ra];
      h_rd_ff <= h_mem[h_ra];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bins_ff    <= 7'd64;
         final_ff   <= 6'd20;
         flat_q8_ff <= 9'd205;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_BINS:  bins_ff    <= pwdata[6:0];
            REG_FINAL: final_ff   <= pwdata[5:0];
            REG_FLAT:  flat_q8_ff <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_BINS:  prdata = {25'd0, bins_ff};
         REG_FINAL: prdata = {26'd0, final_ff};
         REG_FLAT:  prdata = {23'd0, flat_q8_ff};
         default:   prdata = 32'd0;
      endcase
   end
   assign pready = 1'b1;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_idx_ff  <= '0;
         clr_g_ff    <= 1'b1;
         clr_boot_ff <= 1'b1;
         walker_ff   <= '0;
         stage_ff    <= 6'd0;
         total_ff    <= 32'd0;
         acc_ff      <= 1'b0;
         flat_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
               if (state_in != S_CLEAR) clr_boot_ff <= 1'b0;
            end
            S_IDLE: begin
               if (start) begin
                  acc_ff  <= 1'b0;
                  flat_ff <= 1'b0;
                  if (req_word.op == OP_START) begin
                     stage_ff   <= 6'd0;
                     total_ff   <= 32'd0;
                     walker_ff  <= start_bin_w;
                     clr_g_ff   <= 1'b1;
                     clr_idx_ff <= '0;
                  end
               end
            end
            S_CHECK: begin
               if (!acc0_w) acc_ff <= 1'b0;
               else if (gc_ff >= g_rd_ff) acc_ff <= 1'b1;
               else if (x_w >= EXP_LIMIT) acc_ff <= req_ff.random_draw == 16'd0;
            end
            S_PROB:  acc_ff <= !(p_w < {2'd0, req_ff.random_draw, 16'd0});
            S_UPD_WR: begin
               total_ff  <= total_upd_w;
               walker_ff <= cur_w;
            end
            S_FLAT_CMP: begin
               if (state_in == S_CLEAR) begin
                  flat_ff    <= 1'b1;
                  stage_ff   <= stage_ff + 6'd1;
                  total_ff   <= 32'd0;
                  clr_g_ff   <= 1'b0;
                  clr_idx_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_ff <= req_word;
               val_ff <= 64'd0;
            end
         end
         S_RD_CUR: gc_ff <= g_rd_ff;
         S_CHECK: begin
            rem_ff <= x_w[35:0];
            n_ff   <= 5'd0;
         end
         S_REDUCE: begin
            if (rem_ff >= LN2_Q32) begin
               rem_ff <= rem_ff - LN2_Q32;
               n_ff   <= n_ff + 5'd1;
            end else begin
               t_ff <= 33'h1_0000_0000;
               e_ff <= 34'h1_0000_0000;
               k_ff <= 4'd1;
            end
         end
         S_MUL: begin
            dnum_ff <= prod_w[63:32];
            drem_ff <= 4'd0;
            dcnt_ff <= 3'd0;
         end
         S_DIV: begin
            dnum_ff <= {dnum_ff[27:0], dq_w};
            drem_ff <= dr_out_w;
            dcnt_ff <= dcnt_ff + 3'd1;
            if (dcnt_ff == 3'd7) begin
               t_ff <= {1'b0, dnum_ff[27:0], dq_w};
               if (k_ff[0]) e_ff <= e_ff - {2'd0, dnum_ff[27:0], dq_w};
               else e_ff <= e_ff + {2'd0, dnum_ff[27:0], dq_w};
               k_ff <= k_ff + 4'd1;
            end
         end
         S_UPD_WR: begin
            scan_idx_ff <= '0;
            scan_vld_ff <= 1'b0;
            min_ff      <= 32'hFFFF_FFFF;
         end
         S_SCAN: begin
            if (scan_issue_w) scan_idx_ff <= scan_idx_ff + 1'b1;
            scan_vld_ff <= scan_issue_w;
            if (scan_vld_ff && h_rd_ff < min_ff) min_ff <= h_rd_ff;
         end
         S_FLAT_MUL: begin
            lhs_ff <= min_ff * 7'(used_w);
            rhs_ff <= flat_q8_ff * total_ff;
         end
         S_QUERY: val_ff <= g_rd_ff;
         default: ;
      endcase
   end

   // checks
   `WLS_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `WLS_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accepted word did not raise busy")
   `WLS_ASSERT_NOW(a_scan_bound, clock, reset, state_ff == S_SCAN, scan_idx_ff <= used_w, "scan ran past the used bins")
   `WLS_ASSERT_NOW(a_term_bound, clock, reset, state_ff == S_DIV, (k_ff != 4'd0) && (k_ff <= EXP_TERMS), "series term index out of range")
   `WLS_ASSERT_NOW(a_stage_bound, clock, reset, rsp_valid, stage_ff <= MAX_STAGE, "stage beyond its limit")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for the wang-landau sampler: directed table, then random phases
// depends on wls_pkg and the wang_landau_sampler top level
module tb_top;
   import wls_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_word = '0;
   logic        rsp_valid;
   rsp_type     rsp_word;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   wang_landau_sampler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_word(rsp_word), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // shadow state of the sampler
   logic [6:0]  sh_bins  = 7'd64;
   logic [5:0]  sh_final = 6'd20;
   logic [8:0]  sh_flat  = 9'd205;
   logic [63:0] sh_g [BINS];
   logic [31:0] sh_h [BINS];
   logic [5:0]  sh_walker;
   logic [5:0]  sh_stage;
   logic [31:0] sh_total;

   rsp_type expected_rsp [$];
   int          errors = 0;
   logic        row_pinned = 1'b0;
   rsp_type     row_rsp = '0;

   initial begin
      for (int i = 0; i < BINS; i++) begin
         sh_g[i] = '0;
         sh_h[i] = '0;
      end
      sh_walker = '0;
      sh_stage = '0;
      sh_total = '0;
   end

   function automatic int used_count();
      if (sh_bins < 2) return 2;
      if (sh_bins > BINS) return BINS;
      return sh_bins;
   endfunction

   function automatic int last_stage();
      return (sh_final > 32) ? 32 : sh_final;
   endfunction

   // exp(-x) in q0.32 via range reduction and a 12-term series
   function automatic logic [63:0] neg_exp(logic [63:0] x);
      logic [63:0] n, rem, e, t;
      if (x >= (64'd12 << 32)) return 64'd0;
      n = x / 64'd2977044472;
      rem = x - n * 64'd2977044472;
      e = 64'd1 << 32;
      t = 64'd1 << 32;
      for (int k = 1; k <= 12; k++) begin
         t = ((t * rem) >> 32) / k;
         if (k % 2 == 1) e = e - t;
         else e = e + t;
      end
      return e >> n;
   endfunction

   function automatic void clear_hist();
      for (int i = 0; i < BINS; i++) sh_h[i] = '0;
      sh_total = '0;
   endfunction

   // advance the shadow state by one word and return its result
   function automatic rsp_type sample_step(req_type w);
      rsp_type     r;
      int          used;
      int          cur;
      logic        acc;
      logic [63:0] inc, m, gc, gn;
      r = '0;
      used = used_count();
      if (w.op == OP_START) begin
         for (int i = 0; i < BINS; i++) sh_g[i] = '0;
         clear_hist();
         sh_stage = '0;
         sh_walker = (w.bin_index < used) ? w.bin_index : 6'(used - 1);
      end else if (w.op == OP_PROPOSE) begin
         if (sh_stage < last_stage()) begin
            acc = w.in_range && (w.bin_index < used);
            cur = sh_walker;
            if (acc) begin
               gc = sh_g[cur];
               gn = sh_g[w.bin_index];
               if (gc < gn && neg_exp(gn - gc) < ({48'd0, w.random_draw} << 16)) acc = 1'b0;
            end
            if (acc) begin
               cur = w.bin_index;
               sh_walker = w.bin_index;
            end
            r.accepted = acc;
            inc = 64'd1 << (32 - sh_stage);
            if (sh_g[cur] > ~64'd0 - inc) sh_g[cur] = ~64'd0;
            else sh_g[cur] = sh_g[cur] + inc;
            if (sh_h[cur] != ~32'd0) sh_h[cur]++;
            if (sh_total != ~32'd0) sh_total++;
            m = 64'hFFFF_FFFF;
            for (int i = 0; i < used; i++)
               if (sh_h[i] < m) m = sh_h[i];
            if (m > 0 && m * used * 256 >= 64'(sh_flat) * 64'(sh_total)) begin
               clear_hist();
               sh_stage++;
               r.flat_now = 1'b1;
            end
         end
      end else if (w.op == OP_READ) begin
         r.log_density_value = sh_g[w.bin_index];
      end
      r.current_bin = sh_walker;
      r.stage = sh_stage;
      r.finished = (sh_stage >= last_stage());
      return r;
   endfunction

   // accept words and check results at the rising edge
   always @(posedge clock) begin
      rsp_type p, want;
      if (!reset) begin
         if (start && !busy) begin
            p = sample_step(req_word);
            expected_rsp.push_back(row_pinned ? row_rsp : p);
         end
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_word);
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               if (want.accepted !== rsp_word.accepted) begin
                  $display("%0t: accepted exp %h got %h", $time, want.accepted,
                           rsp_word.accepted);
                  errors++;
               end
               if (want.current_bin !== rsp_word.current_bin) begin
                  $display("%0t: current_bin exp %0d got %0d", $time, want.current_bin,
                           rsp_word.current_bin);
                  errors++;
               end
               if (want.stage !== rsp_word.stage) begin
                  $display("%0t: stage exp %0d got %0d", $time, want.stage, rsp_word.stage);
                  errors++;
               end
               if (want.flat_now !== rsp_word.flat_now) begin
                  $display("%0t: flat_now exp %h got %h", $time, want.flat_now,
                           rsp_word.flat_now);
                  errors++;
               end
               if (want.finished !== rsp_word.finished) begin
                  $display("%0t: finished exp %h got %h", $time, want.finished,
                           rsp_word.finished);
                  errors++;
               end
               if (want.log_density_value !== rsp_word.log_density_value) begin
                  $display("%0t: log_density_value exp %h got %h", $time,
                           want.log_density_value, rsp_word.log_density_value);
                  errors++;
               end
            end
         end
      end
   end

   // drive one word and hold it until it is taken
   task automatic send_word(req_type w, logic pin, rsp_type pinned, int gap);
      repeat (gap) @(negedge clock);
      req_word = w;
      row_pinned = pin;
      row_rsp = pinned;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 1'b0;
      row_pinned = 1'b0;
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {idx, 2'b00};
      pwdata = val;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      case (idx)
         REG_BINS:  sh_bins = val[6:0];
         REG_FINAL: sh_final = val[5:0];
         default:   sh_flat = val[8:0];
      endcase
   endtask

   // wait until every result is in and the block has settled
   task automatic drain();
      while (expected_rsp.size() != 0 || busy) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   function automatic req_type mk(logic [1:0] op, logic [5:0] b, logic inr, logic [15:0] r);
      req_type w;
      w.op = op;
      w.bin_index = b;
      w.in_range = inr;
      w.random_draw = r;
      return w;
   endfunction

   typedef struct {
      req_type w;
      logic    pin;
      rsp_type exp_rsp;
   } stim_row;

   stim_row dir_rows [$];

   initial begin
      stim_row sr;
      req_type w;
      int used, roll, gap_mode;
      int bins_set [8]  = '{64, 2, 4, 127, 0, 8, 3, 16};
      int final_set [8] = '{20, 1, 32, 63, 0, 3, 6, 2};
      int flat_set [8]  = '{205, 0, 128, 511, 256, 64, 100, 32};

      repeat (4) @(negedge clock);
      reset = 1'b0;

      // directed table; pinned rows read straight off the reset state
      sr.pin = 1; sr.exp_rsp = '0;
      sr.w = mk(OP_READ, 6'd0, 1'b0, 16'h0000);            dir_rows.push_back(sr);
      sr.w = mk(2'd3, 6'd63, 1'b1, 16'hFFFF);              dir_rows.push_back(sr);
      sr.w = mk(OP_READ, 6'd63, 1'b1, 16'hFFFF);           dir_rows.push_back(sr);
      sr.pin = 0;
      sr.w = mk(OP_PROPOSE, 6'd5, 1'b1, 16'h0000);         dir_rows.push_back(sr);
      sr.w = mk(OP_READ, 6'd5, 1'b0, 16'h0000);            dir_rows.push_back(sr);
      sr.w = mk(OP_START, 6'd63, 1'b0, 16'h0000);          dir_rows.push_back(sr);
      sr.w = mk(OP_PROPOSE, 6'd0, 1'b0, 16'h0000);         dir_rows.push_back(sr);
      sr.w = mk(OP_PROPOSE, 6'd0, 1'b1, 16'hFFFF);         dir_rows.push_back(sr);
      sr.w = mk(OP_PROPOSE, 6'd63, 1'b1, 16'hFFFF);        dir_rows.push_back(sr);
      sr.w = mk(OP_PROPOSE, 6'd63, 1'b1, 16'h0001);        dir_rows.push_back(sr);
      sr.w = mk(OP_PROPOSE, 6'd62, 1'b1, 16'h8000);        dir_rows.push_back(sr);
      sr.w = mk(OP_READ, 6'd63, 1'b0, 16'h0000);           dir_rows.push_back(sr);
      sr.w = mk(OP_READ, 6'd62, 1'b1, 16'hFFFF);           dir_rows.push_back(sr);
      sr.w = mk(2'd3, 6'd0, 1'b0, 16'h0000);               dir_rows.push_back(sr);
      sr.w = mk(OP_START, 6'd0, 1'b1, 16'hFFFF);           dir_rows.push_back(sr);
      sr.w = mk(OP_PROPOSE, 6'd1, 1'b1, 16'h0000);         dir_rows.push_back(sr);
      sr.w = mk(OP_PROPOSE, 6'd0, 1'b1, 16'hFFFF);         dir_rows.push_back(sr);
      sr.w = mk(OP_READ, 6'd1, 1'b0, 16'h0000);            dir_rows.push_back(sr);
      foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].pin, dir_rows[i].exp_rsp, 0);
      drain();

      // random phases, each under its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(REG_BINS, bins_set[ph]);
         csr_write(REG_FINAL, final_set[ph]);
         csr_write(REG_FLAT, flat_set[ph]);
         used = used_count();
         gap_mode = $urandom_range(0, 2);
         send_word(mk(OP_START, 6'($urandom_range(0, 63)), 1'b0, 16'($urandom)), 0, '0, 0);
         for (int n = 0; n < 105; n++) begin
            roll = $urandom_range(0, 99);
            w = mk(OP_PROPOSE, 6'($urandom_range(0, used - 1)),
                   ($urandom_range(0, 9) != 0), 16'($urandom));
            if ($urandom_range(0, 9) == 0) w.bin_index = 6'($urandom);
            if ($urandom_range(0, 3) == 0) w.random_draw = 16'($urandom_range(0, 255));
            if (roll < 4) w.op = OP_START;
            else if (roll < 16) w.op = OP_READ;
            else if (roll < 18) w.op = 2'd3;
            send_word(w, 0, '0, (gap_mode == 0) ? 0 : $urandom_range(0, 16));
            // in phase 2 the sender holds off once, after word 50, until the block has drained
            if (n == 50 && ph == 2) drain();
         end
         drain();
      end

      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // overall watchdog
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
